/* sv/sfc_pkg.sv */
// ----------------------------------------------------------------------------
// sfc_pkg: shared definitions for the spectrum packet framer
// Packet geometry, framing constants, queue entry types and the CRC-16 step.
// ----------------------------------------------------------------------------
package sfc_pkg;

    localparam int BINS       = 512;
    localparam int LAST_INDEX = 2 * BINS;
    localparam int POS_W      = $clog2(LAST_INDEX + 1);

    localparam logic [15:0] CRC_POLY   = 16'hA001;
    localparam logic [15:0] CRC_SEED   = 16'hFFFF;
    localparam logic [7:0]  HDR_FIRST  = 8'hAA;
    localparam logic [7:0]  HDR_SECOND = 8'hBB;

    // One packet word with its place in the packet
    typedef struct packed {
        logic [31:0] word;
        logic        first;
        logic        last;
    } entry_t;

    // Queue status seen by the front and the back
    typedef struct packed {
        logic nonempty;
        logic full;
    } q_stat_t;

    // Reflected CRC-16 update over one byte
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

/* sv/sfc_front.sv */
// ----------------------------------------------------------------------------
// sfc_front: word intake
// Accepts packet words, tags the first and last word of each packet and
// pushes them into the queue.
// ----------------------------------------------------------------------------
module sfc_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [31:0]     data_word,
    input  sfc_pkg::q_stat_t q_stat,
    output logic            push,
    output sfc_pkg::entry_t push_entry
);

    logic [sfc_pkg::POS_W-1:0] pos_reg;
    logic [sfc_pkg::POS_W-1:0] pos_next;
    logic                      is_first;
    logic                      is_last;

    assign is_first = (pos_reg == '0);
    assign is_last  = (pos_reg == sfc_pkg::POS_W'(sfc_pkg::LAST_INDEX));
    assign in_ready = !q_stat.full;
    assign push     = in_valid && in_ready;

    assign push_entry.word  = data_word;
    assign push_entry.first = is_first;
    assign push_entry.last  = is_last;

    always_comb
    begin
        pos_next = pos_reg;
        if (push)
        begin
            pos_next = is_last ? '0 : pos_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

endmodule

/* sv/sfc_queue.sv */
// ----------------------------------------------------------------------------
// sfc_queue: two-entry word queue
// Decouples word intake from byte serialization.
// ----------------------------------------------------------------------------
module sfc_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  sfc_pkg::entry_t  push_entry,
    input  logic             pop,
    output sfc_pkg::entry_t  pop_entry,
    output sfc_pkg::q_stat_t q_stat
);

    sfc_pkg::entry_t mem [0:1];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      count_reg;
    logic [1:0]      count_next;

    assign q_stat.nonempty = (count_reg != 2'd0);
    assign q_stat.full     = (count_reg == 2'd2);
    assign pop_entry       = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

endmodule

/* sv/sfc_back.sv */
// ----------------------------------------------------------------------------
// sfc_back: byte serializer and CRC
// Walks each queued word through header (first only), data and CRC (last only)
// bytes, one byte per cycle while not stalled, updating the CRC-16 and driving the registered output.
// ----------------------------------------------------------------------------
module sfc_back (
    input  logic             clk,
    input  logic             rst_n,
    input  sfc_pkg::q_stat_t q_stat,
    input  sfc_pkg::entry_t  pop_entry,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [7:0]       out_byte,
    output logic             end_of_packet
);

    localparam logic [2:0] STEP_HDR0   = 3'd0;
    localparam logic [2:0] STEP_HDR1   = 3'd1;
    localparam logic [2:0] STEP_B0     = 3'd2;
    localparam logic [2:0] STEP_B1     = 3'd3;
    localparam logic [2:0] STEP_B2     = 3'd4;
    localparam logic [2:0] STEP_B3     = 3'd5;
    localparam logic [2:0] STEP_CRC_LO = 3'd6;
    localparam logic [2:0] STEP_CRC_HI = 3'd7;

    logic        busy_reg;
    logic        busy_next;
    logic [2:0]  step_reg;
    logic [2:0]  step_next;
    logic [31:0] word_reg;
    logic        last_reg;
    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic        eop_reg;

    logic        emit;
    logic        done_now;
    logic        load;
    logic [7:0]  cur_byte;
    logic        cur_is_crc;

    assign out_valid     = out_valid_reg;
    assign out_byte      = out_byte_reg;
    assign end_of_packet = eop_reg;

    assign emit     = busy_reg && (!out_valid_reg || out_ready);
    assign done_now = emit && (((step_reg == STEP_B3) && !last_reg) ||
                               (step_reg == STEP_CRC_HI));
    assign load     = q_stat.nonempty && (!busy_reg || done_now);
    assign pop      = load;

    always_comb
    begin
        cur_is_crc = 1'b0;
        unique case (step_reg)
            STEP_HDR0:   cur_byte = sfc_pkg::HDR_FIRST;
            STEP_HDR1:   cur_byte = sfc_pkg::HDR_SECOND;
            STEP_B0:     cur_byte = word_reg[7:0];
            STEP_B1:     cur_byte = word_reg[15:8];
            STEP_B2:     cur_byte = word_reg[23:16];
            STEP_B3:     cur_byte = word_reg[31:24];
            STEP_CRC_LO:
            begin
                cur_byte   = crc_reg[7:0];
                cur_is_crc = 1'b1;
            end
            default:
            begin
                cur_byte   = crc_reg[15:8];
                cur_is_crc = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        step_next = step_reg;
        busy_next = busy_reg;
        crc_next  = crc_reg;
        if (emit)
        begin
            unique case (step_reg)
                STEP_HDR0:   step_next = STEP_HDR1;
                STEP_HDR1:   step_next = STEP_B0;
                STEP_B0:     step_next = STEP_B1;
                STEP_B1:     step_next = STEP_B2;
                STEP_B2:     step_next = STEP_B3;
                STEP_B3:     step_next = STEP_CRC_LO;
                STEP_CRC_LO: step_next = STEP_CRC_HI;
                default:     step_next = STEP_HDR0;
            endcase
            if (!cur_is_crc)
            begin
                crc_next = sfc_pkg::crc_byte(crc_reg, cur_byte);
            end
            if (done_now)
            begin
                busy_next = 1'b0;
            end
        end
        // A new packet reseeds; it never overlaps a data byte of the old one
        if (load)
        begin
            busy_next = 1'b1;
            step_next = pop_entry.first ? STEP_HDR0 : STEP_B0;
            if (pop_entry.first)
            begin
                crc_next = sfc_pkg::CRC_SEED;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= pop_entry.word;
            last_reg <= pop_entry.last;
        end
        if (emit)
        begin
            out_byte_reg <= cur_byte;
            eop_reg      <= (step_reg == STEP_CRC_HI);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= STEP_HDR0;
            crc_reg       <= sfc_pkg::CRC_SEED;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
            crc_reg  <= crc_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

/* sv/spectrum_packet_framer_crc16_unit.sv */
// ----------------------------------------------------------------------------
// spectrum_packet_framer_crc16_unit: spectrum packet framer with CRC-16
// Frames 2*BINS+1 words per packet into bytes with header and MODBUS CRC.
// ----------------------------------------------------------------------------
// A packet is BINS magnitude words, BINS phase words and one sample rate
// word, taken one 32-bit word per input handshake. Each word leaves as four
// bytes, least significant first; the first word is preceded by 0xAA 0xBB
// and the last is followed by the CRC-16 (poly 0xA001 reflected, seed
// 0xFFFF, low byte first), whose high byte carries end_of_packet. The output
// register delivers one byte per cycle while out_ready takes them, and the
// first and last words of a packet carry two more bytes than the others. A
// two-word queue sits between intake and the byte serializer; an accepted
// word passes the queue, the serializer state and the output register.
module spectrum_packet_framer_crc16_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] data_word,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        end_of_packet
);

    sfc_pkg::q_stat_t q_stat;
    sfc_pkg::entry_t  push_entry;
    sfc_pkg::entry_t  pop_entry;
    logic             push;
    logic             pop;

    sfc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_word  (data_word),
        .q_stat     (q_stat),
        .push       (push),
        .push_entry (push_entry)
    );

    sfc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .q_stat     (q_stat)
    );

    sfc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_stat        (q_stat),
        .pop_entry     (pop_entry),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .end_of_packet (end_of_packet)
    );

    // First and last word of a packet are always distinct words
    a_first_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !(push_entry.first && push_entry.last))
        else $error("word tagged both first and last");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_stat.nonempty)
        else $error("pop from empty queue");

    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_stat.full)
        else $error("push into full queue");

endmodule

/* test/tb_spectrum_packet_framer_crc16_unit.sv */
// ----------------------------------------------------------------------------
// tb_spectrum_packet_framer_crc16_unit: self-checking bench for the framer
// Drives packet words over valid/ready and tracks packet position and the
// running CRC-16 on its own. Compares every emitted byte and its
// end_of_packet flag, in order, against the predicted byte stream.
// Runs corner words at the start of a packet, then random traffic under
// three back-pressure patterns.
// ----------------------------------------------------------------------------
module tb_spectrum_packet_framer_crc16_unit;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PHASE_WORDS  = 51;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 24;

    typedef struct {
        logic [7:0] value;
        logic       eop;
    } framed_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [31:0] data_word = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  out_byte;
    logic        end_of_packet;

    // Predicted framer state
    logic [sfc_pkg::POS_W-1:0] pkt_pos = '0;
    logic [15:0]               pkt_crc = sfc_pkg::CRC_SEED;
    framed_byte_t              expected_bytes[$];

    int errors = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    spectrum_packet_framer_crc16_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_word     (data_word),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .end_of_packet (end_of_packet)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Bit-serial reflected CRC: feed the byte LSB first
    function automatic logic [15:0] crc16_shift_in(input logic [15:0] crc,
                                                   input logic [7:0] b);
        logic [15:0] r;
        r = crc;
        for (int i = 0; i < 8; i++)
        begin
            if (r[0] ^ b[i])
            begin
                r = (r >> 1) ^ sfc_pkg::CRC_POLY;
            end
            else
            begin
                r = r >> 1;
            end
        end
        return r;
    endfunction

    function automatic void queue_byte(input logic [7:0] b, input logic eop,
                                       input logic covered);
        framed_byte_t fb;
        fb.value = b;
        fb.eop   = eop;
        expected_bytes.push_back(fb);
        if (covered)
        begin
            pkt_crc = crc16_shift_in(pkt_crc, b);
        end
    endfunction

    // Expand one accepted word into the bytes the framer must emit
    function automatic void frame_word(input logic [31:0] w);
        logic [15:0] crc_out;
        if (pkt_pos == 0)
        begin
            pkt_crc = sfc_pkg::CRC_SEED;
            queue_byte(sfc_pkg::HDR_FIRST, 1'b0, 1'b1);
            queue_byte(sfc_pkg::HDR_SECOND, 1'b0, 1'b1);
        end
        for (int k = 0; k < 4; k++)
        begin
            queue_byte(w[8*k +: 8], 1'b0, 1'b1);
        end
        if (pkt_pos == sfc_pkg::POS_W'(sfc_pkg::LAST_INDEX))
        begin
            crc_out = pkt_crc;
            queue_byte(crc_out[7:0], 1'b0, 1'b0);
            queue_byte(crc_out[15:8], 1'b1, 1'b0);
            pkt_pos = '0;
            pkt_crc = sfc_pkg::CRC_SEED;
        end
        else
        begin
            pkt_pos = pkt_pos + 1'b1;
        end
    endfunction

    // in_ready only moves at rising edges, so sample it mid-cycle
    task automatic send_word(input logic [31:0] w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_word <= w;
        @(negedge clk);
        while (!in_ready)
        begin
            @(negedge clk);
        end
        @(posedge clk);
        frame_word(w);
    endtask

    function automatic logic [31:0] random_word();
        case ($urandom_range(7))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h1 << $urandom_range(31);
            default: return $urandom;
        endcase
    endfunction

    // Corner words at the start of a packet, header included
    task automatic test_word_extremes();
        logic [31:0] corners [16];
        corners = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000,
                    32'h7FFF_FFFF, 32'hFFFF_FFFE, 32'hAAAA_AAAA, 32'h5555_5555,
                    32'h0000_BBAA, 32'hAABB_AABB, 32'hFF00_FF00, 32'h00FF_00FF,
                    32'h0123_4567, 32'h89AB_CDEF, 32'h3F80_0000, 32'hBF80_0000};
        foreach (corners[i])
        begin
            send_word(corners[i]);
        end
    endtask

    task automatic test_random_traffic(input int count);
        for (int n = 0; n < count; n++)
        begin
            send_word(random_word());
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin : byte_check
        framed_byte_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_bytes.size() == 0)
            begin
                $display("%0t: unexpected byte: expected none, actual %02h eop %b",
                         $time, out_byte, end_of_packet);
                errors++;
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (out_byte !== want.value)
                begin
                    $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                             $time, want.value, out_byte);
                    errors++;
                end
                if (end_of_packet !== want.eop)
                begin
                    $display("%0t: end_of_packet mismatch: expected %b, actual %b",
                             $time, want.eop, end_of_packet);
                    errors++;
                end
            end
        end
    end

    // Abort when neither side moves a word or byte for too long
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        @(posedge rst_n);
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        send_idle_pct = 16;
        recv_idle_pct = 63;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_word_extremes();
        test_random_traffic(PHASE_WORDS);

        send_idle_pct = 63;
        recv_idle_pct = 16;
        test_random_traffic(PHASE_WORDS);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(PHASE_WORDS);

        in_valid <= 1'b0;
        while (expected_bytes.size() != 0)
        begin
            @(posedge clk);
        end
        // catch any stray bytes after the stream drains
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

/* filelist.f */
sv/sfc_pkg.sv
sv/sfc_front.sv
sv/sfc_queue.sv
sv/sfc_back.sv
sv/spectrum_packet_framer_crc16_unit.sv
test/tb_spectrum_packet_framer_crc16_unit.sv
